>>> design/stack_vm_execute_core_macros.svh
// Assertion macros shared by the stack machine RTL.
`ifndef STACK_VM_EXECUTE_CORE_MACROS_SVH
`define STACK_VM_EXECUTE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SVX_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SVX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/svx_pkg.sv
// Shared types and constants of the stack machine execute core.
`default_nettype none
package svx_pkg;

  localparam int unsigned MEM_WORDS_DEF  = 4096;
  localparam int unsigned PROG_WORDS_DEF = 1024;

  localparam logic [6:0] OP_PUSH    = 7'd0;
  localparam logic [6:0] OP_PUSHI   = 7'd1;
  localparam logic [6:0] OP_PUSHC   = 7'd2;
  localparam logic [6:0] OP_POP     = 7'd3;
  localparam logic [6:0] OP_POPI    = 7'd4;
  localparam logic [6:0] OP_DUP     = 7'd5;
  localparam logic [6:0] OP_ALU     = 7'd6;
  localparam logic [6:0] OP_JMP     = 7'd7;
  localparam logic [6:0] OP_JPZ     = 7'd8;
  localparam logic [6:0] OP_CALL    = 7'd9;
  localparam logic [6:0] OP_RET     = 7'd10;
  localparam logic [6:0] OP_RND     = 7'd11;
  localparam logic [6:0] OP_WRITE   = 7'd12;
  localparam logic [6:0] OP_READ    = 7'd13;
  localparam logic [6:0] OP_HALT    = 7'd99;

  localparam logic [3:0] ALU_AND = 4'd0;
  localparam logic [3:0] ALU_OR  = 4'd1;
  localparam logic [3:0] ALU_XOR = 4'd2;
  localparam logic [3:0] ALU_NOT = 4'd3;
  localparam logic [3:0] ALU_NEG = 4'd4;
  localparam logic [3:0] ALU_ADD = 4'd5;
  localparam logic [3:0] ALU_SUB = 4'd6;
  localparam logic [3:0] ALU_MUL = 4'd7;
  localparam logic [3:0] ALU_DIV = 4'd8;
  localparam logic [3:0] ALU_MOD = 4'd9;
  localparam logic [3:0] ALU_NE  = 4'd10;
  localparam logic [3:0] ALU_EQ  = 4'd11;
  localparam logic [3:0] ALU_LE  = 4'd12;
  localparam logic [3:0] ALU_LT  = 4'd13;
  localparam logic [3:0] ALU_GE  = 4'd14;
  localparam logic [3:0] ALU_GT  = 4'd15;

  localparam logic [1:0] FLT_NONE  = 2'd0;
  localparam logic [1:0] FLT_OPC   = 2'd1;
  localparam logic [1:0] FLT_DIV0  = 2'd2;
  localparam logic [1:0] FLT_BOUND = 2'd3;

  // Lowest target an unconditional relative jump (JMP) may reach.
  localparam logic signed [33:0] JMP_FLOOR = -34'sd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDA,
    ST_RDB,
    ST_EXEC,
    ST_DIV,
    ST_TOP,
    ST_TOPW
  } state_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
    logic [31:0] rem;
  } div_res_t;

endpackage
`default_nettype wire

>>> design/svx_div.sv
// Iterative radix-2 divider, signed or unsigned, one quotient bit per cycle.
`default_nettype none
module svx_div (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic             sgn,
  input  wire logic [31:0]      dividend,
  input  wire logic [31:0]      divisor,
  output svx_pkg::div_res_t     res
);

  localparam int unsigned DW = 32;
  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [31:0]   q_r;
  logic [31:0]   rem_r;
  logic [31:0]   den_r;
  logic          qneg_r;
  logic          rneg_r;
  logic [32:0]   rsh;
  logic [32:0]   diff;
  logic [31:0]   a_mag;
  logic [31:0]   b_mag;

  assign a_mag = (sgn && dividend[31]) ? (32'd0 - dividend) : dividend;
  assign b_mag = (sgn && divisor[31])  ? (32'd0 - divisor)  : divisor;
  assign rsh   = {rem_r, q_r[31]};
  assign diff  = rsh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r    <= a_mag;
      rem_r  <= '0;
      den_r  <= b_mag;
      qneg_r <= sgn && (dividend[31] ^ divisor[31]);
      rneg_r <= sgn && dividend[31];
    end else if (busy_r) begin
      if (!diff[32]) begin
        rem_r <= diff[31:0];
        q_r   <= {q_r[30:0], 1'b1};
      end else begin
        rem_r <= rsh[31:0];
        q_r   <= {q_r[30:0], 1'b0};
      end
    end
  end

  assign res.done = done_r;
  assign res.quo  = qneg_r ? (32'd0 - q_r) : q_r;
  assign res.rem  = rneg_r ? (32'd0 - rem_r) : rem_r;

endmodule
`default_nettype wire

>>> design/stack_vm_execute_core.sv
// Stack machine execute core: sequencer, word memory, ALU and shared divider.
// Each item passes through RDA, RDB, EXEC, TOP and TOPW before its result is loaded; div, mod
// and rnd wait in DIV for the 32 divider steps unless they fault, and a halted item goes to TOP.
// The core takes no new item until the last result is loaded; a waiting result holds the next.
// Synchronous active-low reset clears pc, stack pointer, halt flag and all handshake state;
// the word memory is not cleared. MemWords and ProgWords must be powers of two.
`default_nettype none
`include "stack_vm_execute_core_macros.svh"
module stack_vm_execute_core #(
  parameter int unsigned MemWords  = svx_pkg::MEM_WORDS_DEF,
  parameter int unsigned ProgWords = svx_pkg::PROG_WORDS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [6:0]         in_opcode,
  input  wire logic signed [31:0] in_operand,
  input  wire logic signed [31:0] in_read_value,
  input  wire logic [30:0]        in_random_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [9:0]              out_next_pc,
  output logic [11:0]             out_stack_depth,
  output logic signed [31:0]      out_top_word,
  output logic signed [31:0]      out_print_value,
  output logic                    out_print_valid,
  output logic                    out_halted,
  output logic [1:0]              out_fault_code
);

  localparam int unsigned AW = $clog2(MemWords);
  localparam int unsigned PW = $clog2(ProgWords);

  // Sequencer and architectural state.
  svx_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]   sp_r, sp_nxt;
  logic [PW-1:0]   pc_r, pc_nxt;
  logic            halt_r, halt_nxt;
  logic [31:0]     pval_r, pval_nxt;
  logic            pvld_r, pvld_nxt;
  logic [1:0]      flt_r, flt_nxt;

  // The current item, held for the whole instruction.
  logic [6:0]         opc_r;
  logic signed [31:0] opd_r;
  logic [31:0]        rdv_r;
  logic [30:0]        rnd_r;
  logic [31:0]        a_r;

  // Word memory shared by data and stack, one write and one registered read port.
  logic [31:0]   mem [MemWords];
  logic [31:0]   rdata_r;
  logic [AW-1:0] ra;
  logic [AW-1:0] wa;
  logic [31:0]   wd;
  logic          we;

  // Shared divider.
  logic               div_start;
  logic               div_sgn;
  logic [31:0]        div_a;
  logic [31:0]        div_b;
  svx_pkg::div_res_t  div_res;

  // Output register.
  logic        out_valid_r;
  logic        load;
  logic        acc;

  // Helpers.
  logic [AW-1:0]      sp_m1;
  logic [AW-1:0]      sp_m2;
  logic [AW-1:0]      sp_p1;
  logic [3:0]         sel;
  logic               sel_ok;
  logic signed [31:0] sa;
  logic signed [31:0] sb;
  logic [31:0]        alu_r;
  logic [31:0]        prod;
  logic signed [33:0] pc_s;
  logic signed [33:0] opd_s;
  logic signed [33:0] tgt;
  logic signed [33:0] jsum;
  logic signed [32:0] bound;

  assign sp_m1  = sp_r - AW'(1);
  assign sp_m2  = sp_r - AW'(2);
  assign sp_p1  = sp_r + AW'(1);
  assign sel    = opd_r[3:0];
  assign sel_ok = (opd_r[31:4] == 28'd0);
  assign sa     = signed'(a_r);
  assign sb     = signed'(rdata_r);
  assign prod   = a_r * rdata_r;
  assign pc_s   = signed'(34'(pc_r));
  assign opd_s  = {{2{opd_r[31]}}, opd_r};
  assign jsum   = pc_s + opd_s;
  assign bound  = {opd_r[31], opd_r} - 33'sd1;

  assign acc       = in_valid && (state_r == svx_pkg::ST_IDLE);
  assign in_stall  = (state_r != svx_pkg::ST_IDLE);
  assign load      = (state_r == svx_pkg::ST_TOPW) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;

  // ALU result for every selector; NOT and NEG use the top only, else second is left, top is right.
  always_comb begin
    unique case (sel)
      svx_pkg::ALU_AND: alu_r = a_r & rdata_r;
      svx_pkg::ALU_OR:  alu_r = a_r | rdata_r;
      svx_pkg::ALU_XOR: alu_r = a_r ^ rdata_r;
      svx_pkg::ALU_NOT: alu_r = ~rdata_r;
      svx_pkg::ALU_NEG: alu_r = 32'd0 - rdata_r;
      svx_pkg::ALU_ADD: alu_r = a_r + rdata_r;
      svx_pkg::ALU_SUB: alu_r = a_r - rdata_r;
      svx_pkg::ALU_MUL: alu_r = prod;
      svx_pkg::ALU_DIV: alu_r = div_res.quo;
      svx_pkg::ALU_MOD: alu_r = div_res.rem;
      svx_pkg::ALU_NE:  alu_r = {31'd0, sa != sb};
      svx_pkg::ALU_EQ:  alu_r = {31'd0, sa == sb};
      svx_pkg::ALU_LE:  alu_r = {31'd0, sa <= sb};
      svx_pkg::ALU_LT:  alu_r = {31'd0, sa < sb};
      svx_pkg::ALU_GE:  alu_r = {31'd0, sa >= sb};
      svx_pkg::ALU_GT:  alu_r = {31'd0, sa > sb};
      default:          alu_r = '0;
    endcase
  end

  // Sequencer. Two reads (RDA, RDB) fetch the operands, EXEC performs the
  // instruction and at most one memory write, DIV waits for the divider and
  // writes its result, and TOP/TOPW read the new top of stack for the result.
  always_comb begin
    state_nxt = state_r;
    sp_nxt    = sp_r;
    pc_nxt    = pc_r;
    halt_nxt  = halt_r;
    pval_nxt  = pval_r;
    pvld_nxt  = pvld_r;
    flt_nxt   = flt_r;
    ra        = sp_m1;
    we        = 1'b0;
    wa        = sp_r;
    wd        = '0;
    div_start = 1'b0;
    div_sgn   = 1'b1;
    div_a     = a_r;
    div_b     = rdata_r;
    tgt       = pc_s;

    unique case (state_r)
      svx_pkg::ST_IDLE: begin
        if (acc) begin
          pval_nxt  = '0;
          pvld_nxt  = 1'b0;
          flt_nxt   = svx_pkg::FLT_NONE;
          state_nxt = halt_r ? svx_pkg::ST_TOP : svx_pkg::ST_RDA;
        end
      end

      svx_pkg::ST_RDA: begin
        // First operand: operand address, second-from-top for the ALU, else top.
        if (opc_r == svx_pkg::OP_PUSH || opc_r == svx_pkg::OP_WRITE) begin
          ra = opd_r[AW-1:0];
        end else if (opc_r == svx_pkg::OP_ALU) begin
          ra = sp_m2;
        end else begin
          ra = sp_m1;
        end
        state_nxt = svx_pkg::ST_RDB;
      end

      svx_pkg::ST_RDB: begin
        // Second operand: indirect push follows the word just read.
        if (opc_r == svx_pkg::OP_PUSHI) begin
          ra = rdata_r[AW-1:0];
        end else if (opc_r == svx_pkg::OP_POPI) begin
          ra = sp_m2;
        end else begin
          ra = sp_m1;
        end
        state_nxt = svx_pkg::ST_EXEC;
      end

      svx_pkg::ST_EXEC: begin
        state_nxt = svx_pkg::ST_TOP;
        unique case (opc_r)
          svx_pkg::OP_PUSH: begin
            we = 1'b1; wa = sp_r; wd = a_r; sp_nxt = sp_p1;
          end
          svx_pkg::OP_PUSHI: begin
            we = 1'b1; wa = sp_m1; wd = rdata_r;
          end
          svx_pkg::OP_PUSHC: begin
            we = 1'b1; wa = sp_r; wd = opd_r; sp_nxt = sp_p1;
          end
          svx_pkg::OP_POP: begin
            we = 1'b1; wa = opd_r[AW-1:0]; wd = a_r; sp_nxt = sp_m1;
          end
          svx_pkg::OP_POPI: begin
            we = 1'b1; wa = a_r[AW-1:0]; wd = rdata_r; sp_nxt = sp_m2;
          end
          svx_pkg::OP_DUP: begin
            we = 1'b1; wa = sp_r; wd = a_r; sp_nxt = sp_p1;
          end
          svx_pkg::OP_ALU: begin
            if (sel_ok) begin
              if (sel == svx_pkg::ALU_NOT || sel == svx_pkg::ALU_NEG) begin
                we = 1'b1; wa = sp_m1; wd = alu_r;
              end else if (sel == svx_pkg::ALU_DIV || sel == svx_pkg::ALU_MOD) begin
                if (rdata_r == 32'd0) begin
                  flt_nxt = svx_pkg::FLT_DIV0;
                end else begin
                  div_start = 1'b1;
                  state_nxt = svx_pkg::ST_DIV;
                end
              end else begin
                we = 1'b1; wa = sp_m2; wd = alu_r; sp_nxt = sp_m1;
              end
            end
          end
          svx_pkg::OP_JMP: begin
            tgt = (jsum < svx_pkg::JMP_FLOOR) ? svx_pkg::JMP_FLOOR : jsum;
          end
          svx_pkg::OP_JPZ: begin
            sp_nxt = sp_m1;
            if (a_r == 32'd0) begin
              tgt = jsum;
            end
          end
          svx_pkg::OP_CALL: begin
            we = 1'b1; wa = sp_r; wd = 32'(pc_r); sp_nxt = sp_p1; tgt = jsum;
          end
          svx_pkg::OP_RET: begin
            tgt = {{2{a_r[31]}}, a_r}; sp_nxt = sp_m1;
          end
          svx_pkg::OP_RND: begin
            if (bound < 33'sd1) begin
              flt_nxt = svx_pkg::FLT_BOUND;
            end else begin
              div_start = 1'b1;
              div_sgn   = 1'b0;
              div_a     = {1'b0, rnd_r};
              div_b     = bound[31:0];
              state_nxt = svx_pkg::ST_DIV;
            end
          end
          svx_pkg::OP_WRITE: begin
            pval_nxt = a_r; pvld_nxt = 1'b1;
          end
          svx_pkg::OP_READ: begin
            we = 1'b1; wa = opd_r[AW-1:0]; wd = rdv_r;
          end
          svx_pkg::OP_HALT: begin
            halt_nxt = 1'b1;
          end
          default: begin
            flt_nxt = svx_pkg::FLT_OPC;
          end
        endcase
        pc_nxt = PW'(tgt + 34'sd1);
      end

      svx_pkg::ST_DIV: begin
        if (div_res.done) begin
          state_nxt = svx_pkg::ST_TOP;
          we = 1'b1;
          if (opc_r == svx_pkg::OP_RND) begin
            wa = sp_r; wd = div_res.rem; sp_nxt = sp_p1;
          end else begin
            wa = sp_m2; wd = alu_r; sp_nxt = sp_m1;
          end
        end
      end

      svx_pkg::ST_TOP: begin
        state_nxt = svx_pkg::ST_TOPW;
      end

      svx_pkg::ST_TOPW: begin
        // The top-of-stack address stays on the read port while the result waits.
        if (load) begin
          state_nxt = svx_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = svx_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= svx_pkg::ST_IDLE;
      sp_r    <= '0;
      pc_r    <= '0;
      halt_r  <= 1'b0;
      pval_r  <= '0;
      pvld_r  <= 1'b0;
      flt_r   <= svx_pkg::FLT_NONE;
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
      pc_r    <= pc_nxt;
      halt_r  <= halt_nxt;
      pval_r  <= pval_nxt;
      pvld_r  <= pvld_nxt;
      flt_r   <= flt_nxt;
    end
  end

  // Item capture and the first operand.
  always_ff @(posedge clk) begin
    if (acc) begin
      opc_r <= in_opcode;
      opd_r <= in_operand;
      rdv_r <= in_read_value;
      rnd_r <= in_random_value;
    end
    if (state_r == svx_pkg::ST_RDB) begin
      a_r <= rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[ra];
  end

  svx_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .sgn      (div_sgn),
    .dividend (div_a),
    .divisor  (div_b),
    .res      (div_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_next_pc     <= 10'(pc_r);
      out_stack_depth <= 12'(sp_r);
      out_top_word    <= rdata_r;
      out_print_value <= pval_r;
      out_print_valid <= pvld_r;
      out_halted      <= halt_r;
      out_fault_code  <= flt_r;
    end
  end

  // Once halted, the machine stays halted until reset.
  `SVX_ASSERT_NEXT(a_halt_sticks, halt_r, halt_r, "halt flag cleared without reset")
  // A divider result only arrives while the sequencer waits for it.
  `SVX_ASSERT_NOW(a_div_done_state, div_res.done, state_r == svx_pkg::ST_DIV,
                  "stray divider result")
  // A write instruction never reports a fault.
  `SVX_ASSERT_NOW(a_print_no_fault, out_valid_r && out_print_valid,
                  out_fault_code == svx_pkg::FLT_NONE, "print with fault")

endmodule
`default_nettype wire
